// ===== sv/mpc_pkg.sv =====
// Shared types, constants and helpers for the Mandelbrot pixel colour block.
// Used by mpc_ctrl, mpc_datapath and mandelbrot_pixel_colour. No dependencies.
package mpc_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int FIX_W      = 32;
  localparam int ITER_W     = 16;
  localparam int COLOR_W    = 8;
  localparam int PROD_W     = 2 * FIX_W;
  localparam int CPROD_W    = FIX_W + COORD_BITS + 1;
  localparam int SAT_W      = CPROD_W + 1;
  localparam int DIV_STEPS  = COLOR_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int NUM_CH     = 3;

  localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_BITS + 3 * COLOR_W + ITER_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = FIX_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_RE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM   = 3'd4;

  localparam logic [ITER_W-1:0]       RST_MAX_ITER  = 16'd256;
  localparam logic signed [FIX_W-1:0] RST_ORIGIN_RE = -32'sd536870912;
  localparam logic signed [FIX_W-1:0] RST_ORIGIN_IM = -32'sd268435456;
  localparam logic signed [FIX_W-1:0] RST_STEP_RE   = 32'sd1258291;
  localparam logic signed [FIX_W-1:0] RST_STEP_IM   = 32'sd1118481;

  // escape when |z|^2 > 4 in Q8.56
  localparam logic [PROD_W-1:0] MAG_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

  localparam logic [COLOR_W-1:0] RED_NUM    = 8'd255;
  localparam logic [COLOR_W-1:0] GREEN_NUM  = 8'd128;
  localparam logic [COLOR_W-1:0] BLUE_NUM   = 8'd64;
  localparam logic [COLOR_W-1:0] COLOR_BASE = 8'd200;

  localparam logic signed [SAT_W-1:0] SAT_HI =
    {{(SAT_W-FIX_W+1){1'b0}}, {(FIX_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_LO =
    {{(SAT_W-FIX_W+1){1'b1}}, {(FIX_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_C_MUL,
    ST_C_ADD,
    ST_Z_MUL,
    ST_Z_UPD,
    ST_DIV,
    ST_FINISH
  } mpc_state_t;

  typedef struct packed {
    logic load_in;
    logic c_mul;
    logic c_add;
    logic z_mul;
    logic z_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } mpc_cmd_t;

  typedef struct packed {
    logic escape;
    logic at_max;
    logic div_last;
  } mpc_status_t;

  function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [SAT_W-1:0] v);
    logic signed [FIX_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[FIX_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[FIX_W-1:0];
    end else begin
      r = v[FIX_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/mpc_ctrl.sv =====
// Controller FSM for the Mandelbrot pixel colour block: sequences c setup,
// the z iteration loop, the colour divider and the output register. Uses mpc_pkg.
module mpc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  mpc_pkg::mpc_status_t st,
  output mpc_pkg::mpc_cmd_t    cmd
);

  mpc_pkg::mpc_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpc_pkg::ST_IDLE:   if (in_tvalid) state_nxt = mpc_pkg::ST_C_MUL;
      mpc_pkg::ST_C_MUL:  state_nxt = mpc_pkg::ST_C_ADD;
      mpc_pkg::ST_C_ADD:  state_nxt = mpc_pkg::ST_Z_MUL;
      mpc_pkg::ST_Z_MUL:  state_nxt = mpc_pkg::ST_Z_UPD;
      mpc_pkg::ST_Z_UPD: begin
        if (st.escape) begin
          state_nxt = mpc_pkg::ST_DIV;
        end else if (st.at_max) begin
          state_nxt = mpc_pkg::ST_FINISH;
        end else begin
          state_nxt = mpc_pkg::ST_Z_MUL;
        end
      end
      mpc_pkg::ST_DIV:    if (st.div_last) state_nxt = mpc_pkg::ST_FINISH;
      mpc_pkg::ST_FINISH: if (out_free) state_nxt = mpc_pkg::ST_IDLE;
      default:            state_nxt = mpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      mpc_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      mpc_pkg::ST_C_MUL:  cmd.c_mul = 1'b1;
      mpc_pkg::ST_C_ADD:  cmd.c_add = 1'b1;
      mpc_pkg::ST_Z_MUL:  cmd.z_mul = 1'b1;
      mpc_pkg::ST_Z_UPD: begin
        cmd.div_init = st.escape;
        cmd.z_step   = !st.escape && !st.at_max;
      end
      mpc_pkg::ST_DIV:    cmd.div_step = 1'b1;
      mpc_pkg::ST_FINISH: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // output register never overwritten while a result waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register loaded while full");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == mpc_pkg::ST_C_MUL)
    else $error("accepted pixel did not start c setup");

  a_escape_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mpc_pkg::ST_Z_UPD && st.escape) |=> state_r == mpc_pkg::ST_DIV)
    else $error("escape did not start the divider");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == mpc_pkg::ST_FINISH)
    else $error("result shown outside finish");

endmodule

// ===== sv/mpc_datapath.sv =====
// Datapath for the Mandelbrot pixel colour block: config registers, c setup,
// shared complex square-and-add unit, 8-step colour divider, result register. Uses mpc_pkg.
module mpc_datapath (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  input  logic [mpc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mpc_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic [mpc_pkg::COORD_BITS-1:0]         in_column,
  input  logic [mpc_pkg::COORD_BITS-1:0]         in_row,
  input  mpc_pkg::mpc_cmd_t                      cmd,
  output mpc_pkg::mpc_status_t                   st,
  output logic [mpc_pkg::COORD_BITS-1:0]         out_column,
  output logic [mpc_pkg::COORD_BITS-1:0]         out_row,
  output logic [mpc_pkg::COLOR_W-1:0]            out_red,
  output logic [mpc_pkg::COLOR_W-1:0]            out_green,
  output logic [mpc_pkg::COLOR_W-1:0]            out_blue,
  output logic                                   out_escaped,
  output logic [mpc_pkg::ITER_W-1:0]             out_escape_count
);

  localparam int FW = mpc_pkg::FIX_W;
  localparam int PW = mpc_pkg::PROD_W;
  localparam int CW = mpc_pkg::CPROD_W;
  localparam int SW = mpc_pkg::SAT_W;
  localparam int KW = mpc_pkg::ITER_W;
  localparam int QW = mpc_pkg::COLOR_W;
  localparam int NC = mpc_pkg::NUM_CH;

  // configuration
  logic [KW-1:0]        max_iter_r;
  logic signed [FW-1:0] origin_re_r, origin_im_r, step_re_r, step_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r  <= mpc_pkg::RST_MAX_ITER;
      origin_re_r <= mpc_pkg::RST_ORIGIN_RE;
      origin_im_r <= mpc_pkg::RST_ORIGIN_IM;
      step_re_r   <= mpc_pkg::RST_STEP_RE;
      step_im_r   <= mpc_pkg::RST_STEP_IM;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mpc_pkg::CFG_MAX_ITER:  max_iter_r  <= cfg_data[KW-1:0];
        mpc_pkg::CFG_ORIGIN_RE: origin_re_r <= cfg_data;
        mpc_pkg::CFG_ORIGIN_IM: origin_im_r <= cfg_data;
        mpc_pkg::CFG_STEP_RE:   step_re_r   <= cfg_data;
        mpc_pkg::CFG_STEP_IM:   step_im_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // pixel coordinates and c
  logic [mpc_pkg::COORD_BITS-1:0] col_r, row_r;
  logic signed [CW-1:0]           pc_re_r, pc_im_r;
  logic signed [FW-1:0]           cr_r, ci_r;
  logic signed [CW-1:0]           pc_re_nxt, pc_im_nxt;
  logic signed [SW-1:0]           c_re_sum, c_im_sum;

  assign pc_re_nxt = CW'(step_re_r) * CW'(signed'({1'b0, col_r}));
  assign pc_im_nxt = CW'(step_im_r) * CW'(signed'({1'b0, row_r}));
  assign c_re_sum  = SW'(origin_re_r) + SW'(pc_re_r);
  assign c_im_sum  = SW'(origin_im_r) + SW'(pc_im_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      col_r <= in_column;
      row_r <= in_row;
    end
    if (cmd.c_mul) begin
      pc_re_r <= pc_re_nxt;
      pc_im_r <= pc_im_nxt;
    end
    if (cmd.c_add) begin
      cr_r <= mpc_pkg::sat_fix(c_re_sum);
      ci_r <= mpc_pkg::sat_fix(c_im_sum);
    end
  end

  // z iteration: products registered, then update and escape test
  logic signed [FW-1:0] zr_r, zi_r;
  logic signed [PW-1:0] rr_r, ii_r, ri_r;
  logic signed [PW-1:0] zr_ext, zi_ext, diff, diff_sh, ri_sh;
  logic signed [SW-1:0] nr_sum, ni_sum;
  logic [PW-1:0]        mag;
  logic [KW-1:0]        k_r;
  logic                 escaped_r;

  assign zr_ext  = PW'(zr_r);
  assign zi_ext  = PW'(zi_r);
  assign diff    = rr_r - ii_r;
  assign diff_sh = diff >>> mpc_pkg::FRAC_BITS;
  assign ri_sh   = ri_r >>> (mpc_pkg::FRAC_BITS - 1);
  assign nr_sum  = SW'(diff_sh) + SW'(cr_r);
  assign ni_sum  = SW'(ri_sh) + SW'(ci_r);
  // both squares are non-negative, so the sum cannot wrap
  assign mag     = $unsigned(rr_r) + $unsigned(ii_r);

  assign st.escape = (k_r != '0) && (mag > mpc_pkg::MAG_LIMIT);
  assign st.at_max = (k_r == max_iter_r);

  always_ff @(posedge clk) begin
    if (cmd.c_add) begin
      zr_r      <= '0;
      zi_r      <= '0;
      k_r       <= '0;
      escaped_r <= 1'b0;
    end else if (cmd.z_step) begin
      zr_r <= mpc_pkg::sat_fix(nr_sum);
      zi_r <= mpc_pkg::sat_fix(ni_sum);
      k_r  <= k_r + KW'(1);
    end else if (cmd.div_init) begin
      escaped_r <= 1'b1;
    end
    if (cmd.z_mul) begin
      rr_r <= zr_ext * zr_ext;
      ii_r <= zi_ext * zi_ext;
      ri_r <= zr_ext * zi_ext;
    end
  end

  // restoring divider: 255/k, 128/k, 64/k side by side, one bit a cycle
  logic [QW-1:0]                  num [NC];
  logic [QW-1:0]                  rem_r [NC];
  logic [QW-1:0]                  q_r [NC];
  logic [QW:0]                    shifted [NC];
  logic                           ge [NC];
  logic [mpc_pkg::DIV_CNT_W-1:0]  div_cnt_r;
  logic [mpc_pkg::DIV_CNT_W-1:0]  bit_sel;

  assign num[0]      = mpc_pkg::RED_NUM;
  assign num[1]      = mpc_pkg::GREEN_NUM;
  assign num[2]      = mpc_pkg::BLUE_NUM;
  assign bit_sel     = mpc_pkg::DIV_CNT_W'(mpc_pkg::DIV_STEPS - 1) - div_cnt_r;
  assign st.div_last = (div_cnt_r == mpc_pkg::DIV_CNT_W'(mpc_pkg::DIV_STEPS - 1));

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      shifted[i] = {rem_r[i], num[i][bit_sel]};
      ge[i]      = {{(KW-QW){1'b0}}, shifted[i]} >= {1'b0, k_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_cnt_r <= '0;
      for (int i = 0; i < NC; i++) begin
        rem_r[i] <= '0;
        q_r[i]   <= '0;
      end
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + mpc_pkg::DIV_CNT_W'(1);
      for (int i = 0; i < NC; i++) begin
        // remainder stays below k and no larger than the numerator, so it fits in QW bits
        rem_r[i] <= ge[i] ? QW'(shifted[i] - k_r[QW:0]) : shifted[i][QW-1:0];
        q_r[i]   <= {q_r[i][QW-2:0], ge[i]};
      end
    end
  end

  // result register
  logic [mpc_pkg::COORD_BITS-1:0] res_col_r, res_row_r;
  logic [QW-1:0]                  res_red_r, res_green_r, res_blue_r;
  logic                           res_esc_r;
  logic [KW-1:0]                  res_cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_col_r   <= col_r;
      res_row_r   <= row_r;
      res_esc_r   <= escaped_r;
      res_red_r   <= escaped_r ? q_r[0] : '0;
      res_green_r <= escaped_r ? (mpc_pkg::COLOR_BASE - q_r[1]) : '0;
      res_blue_r  <= escaped_r ? (mpc_pkg::COLOR_BASE - q_r[2]) : '0;
      res_cnt_r   <= escaped_r ? k_r : '0;
    end
  end

  assign out_column       = res_col_r;
  assign out_row          = res_row_r;
  assign out_escaped      = res_esc_r;
  assign out_red          = res_red_r;
  assign out_green        = res_green_r;
  assign out_blue         = res_blue_r;
  assign out_escape_count = res_cnt_r;

endmodule

// ===== sv/mandelbrot_pixel_colour.sv =====
// From input transfer to result the FSM steps through c multiply and c add, then a z
// multiply and a z update state per z step on the shared multiply/update unit, then the
// colour divide after an escape, and the finish state that loads the result register.
// Throughput: one pixel at a time; the next is taken once the result is registered.
// Reset (rst_n low, synchronous): FSM idle, no result pending, config to defaults.
module mandelbrot_pixel_colour (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [mpc_pkg::IN_DATA_W-1:0]      in_tdata,   // column, row
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_column, out_row, red, green, blue, escape_count
  output logic [mpc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [0:0]                         out_tuser,  // escaped
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CB = mpc_pkg::COORD_BITS;

  mpc_pkg::mpc_cmd_t    cmd;
  mpc_pkg::mpc_status_t st;

  logic [CB-1:0]                    o_col, o_row;
  logic [mpc_pkg::COLOR_W-1:0]      o_red, o_green, o_blue;
  logic                             o_esc;
  logic [mpc_pkg::ITER_W-1:0]       o_cnt;

  assign cfg_ready = 1'b1;

  mpc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  mpc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_column        (in_tdata[CB-1:0]),
    .in_row           (in_tdata[2*CB-1:CB]),
    .cmd              (cmd),
    .st               (st),
    .out_column       (o_col),
    .out_row          (o_row),
    .out_red          (o_red),
    .out_green        (o_green),
    .out_blue         (o_blue),
    .out_escaped      (o_esc),
    .out_escape_count (o_cnt)
  );

  assign out_tdata = mpc_pkg::OUT_DATA_W'({o_cnt, o_blue, o_green, o_red, o_row, o_col});
  assign out_tuser = o_esc;

endmodule
